// File: hdl/assert_macros.svh
// assertion helpers used by the timer queue datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge outside reset
`define OTQ_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication outside reset
`define OTQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/otq_pkg.sv
// ---------------------------------------------------------------------------
// otq_pkg
// Types and codes shared by the ordered timer queue modules.
// ---------------------------------------------------------------------------
package otq_pkg;

  // operation codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_EXPIRE = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

  // most timers fired by one expire, and the width of its counter
  localparam int MAX_FIRE = 16;
  localparam int FIRE_W   = 5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] alarm_at;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [63:0] now;
  } otq_cmd_t;

  typedef struct packed {
    logic [3:0]  handle;
    logic        fired;
    logic [31:0] fired_tag;
    logic [1:0]  status;
    logic        alarm_on;
    logic [63:0] next_alarm;
    logic        reprogram;
    logic        last;
  } otq_res_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       add_write;
    logic       chg_write;
    logic       del_clear;
    logic       rd_req;
    logic       scan_start;
    logic       scan_step;
    logic       fire;
    logic       emit_final;
    logic       final_update;
    logic [1:0] final_status;
  } otq_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       slot_ok;
    logic       same_time;
    logic       scan_end;
    logic       fire_ready;
    logic       out_free;
  } otq_sts_t;

endpackage

// File: hdl/otq_ctrl.sv
// ---------------------------------------------------------------------------
// otq_ctrl
// Sequencer for the timer queue: decodes an operation, runs the slot scans
// and orders the fired and final result transfers.
// ---------------------------------------------------------------------------
module otq_ctrl
  import otq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  otq_sts_t sts,
  output otq_ctl_t ctl
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_PICK   = 7'b0010000,
    S_FIRE   = 7'b0100000,
    S_FINAL  = 7'b1000000
  } otq_state_t;

  otq_state_t state, state_next;
  logic [1:0] fin_status, fin_status_next;
  logic       fin_update, fin_update_next;

  // input side only takes a transfer between operations
  assign cmd_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    ctl             = '0;
    state_next      = state;
    fin_status_next = fin_status;
    fin_update_next = fin_update;
    ctl.final_status = fin_status;
    ctl.final_update = fin_update;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_ADD: begin
            if (sts.full) begin
              fin_status_next = STATUS_FULL;
              fin_update_next = 1'b0;
              state_next      = S_FINAL;
            end else begin
              ctl.add_write  = 1'b1;
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          KIND_CHANGE: begin
            if (!sts.slot_ok) begin
              fin_status_next = STATUS_BAD_SLOT;
              fin_update_next = 1'b0;
              state_next      = S_FINAL;
            end else begin
              ctl.rd_req = 1'b1;
              state_next = S_CHECK;
            end
          end
          KIND_DELETE: begin
            if (!sts.slot_ok) begin
              fin_status_next = STATUS_BAD_SLOT;
              fin_update_next = 1'b0;
              state_next      = S_FINAL;
            end else begin
              ctl.del_clear  = 1'b1;
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            ctl.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        endcase
      end
      S_CHECK: begin
        // a change to the same time leaves the timer alone
        if (sts.same_time) begin
          fin_status_next = STATUS_OK;
          fin_update_next = 1'b0;
          state_next      = S_FINAL;
        end else begin
          ctl.chg_write  = 1'b1;
          ctl.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_end) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (sts.kind == KIND_EXPIRE && sts.fire_ready) begin
          state_next = S_FIRE;
        end else begin
          fin_status_next = STATUS_OK;
          fin_update_next = 1'b1;
          state_next      = S_FINAL;
        end
      end
      S_FIRE: begin
        if (sts.out_free) begin
          ctl.fire       = 1'b1;
          ctl.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          ctl.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= STATUS_OK;
      fin_update <= 1'b0;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
      fin_update <= fin_update_next;
    end
  end

endmodule

// File: hdl/otq_datapath.sv
// ---------------------------------------------------------------------------
// otq_datapath
// Slot memories, in-use flags, earliest-timer scan, alarm record and the
// result register of the timer queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module otq_datapath
  import otq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  otq_cmd_t cmd,
  input  otq_ctl_t ctl,
  output otq_sts_t sts,
  output logic     res_valid,
  input  logic     res_stall,
  output otq_res_t res
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // captured operation
  otq_cmd_t req;

  // slot storage
  logic [63:0] time_mem  [SLOTS];
  logic [31:0] tag_mem   [SLOTS];
  logic [63:0] order_mem [SLOTS];
  logic [SLOTS-1:0] used;

  logic [63:0]       order_cnt;
  logic [63:0]       prog_time;
  logic              alarm_en;
  logic [3:0]        hnd;
  logic [FIRE_W-1:0] nfire;

  // read port
  logic [SW-1:0] rd_addr;
  logic [63:0]   rd_time, rd_order;
  logic [31:0]   rd_tag;
  logic [SW-1:0] rd_idx;
  logic          rd_live;
  logic          rd_issue;

  // scan state
  logic [CW-1:0] scan_cnt;
  logic          best_found;
  logic [63:0]   best_time, best_order;
  logic [31:0]   best_tag;
  logic [SW-1:0] best_idx;
  logic          better;

  logic [SW-1:0] free_idx, req_idx, wr_addr;
  logic          full, wr_en, slot_ok, reprog;
  logic [63:0]   upd_time;
  logic          loading;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_idx = SW'(i);
        full     = 1'b0;
      end
    end
  end

  assign req_idx = SW'(req.slot);
  assign slot_ok = (32'(req.slot) < SLOTS) && used[req_idx];

  // write port: add takes the free slot, change rewrites the named slot
  assign wr_en   = ctl.add_write || ctl.chg_write;
  assign wr_addr = ctl.add_write ? free_idx : req_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr]  <= req.alarm_at;
      order_mem[wr_addr] <= order_cnt;
    end
    if (ctl.add_write) begin
      tag_mem[wr_addr] <= req.tag;
    end
  end

  // read port: scan index during a scan, otherwise the named slot
  assign rd_issue = ctl.scan_step && (scan_cnt < CW'(SLOTS));
  assign rd_addr  = ctl.scan_step ? scan_cnt[SW-1:0] : req_idx;

  always_ff @(posedge clk) begin
    rd_time  <= time_mem[rd_addr];
    rd_order <= order_mem[rd_addr];
    rd_tag   <= tag_mem[rd_addr];
    rd_idx   <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= rd_issue && used[rd_addr];
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      scan_cnt <= '0;
    end else if (rd_issue) begin
      scan_cnt <= scan_cnt + CW'(1);
    end
  end

  // earliest by time, then by order stamp
  assign better = !best_found || (rd_time < best_time) ||
                  ((rd_time == best_time) && (rd_order < best_order));

  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      best_found <= 1'b0;
    end else if (rd_live && better) begin
      best_found <= 1'b1;
      best_time  <= rd_time;
      best_order <= rd_order;
      best_tag   <= rd_tag;
      best_idx   <= rd_idx;
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req <= cmd;
    end
  end

  // handle for the final result
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hnd <= (cmd.kind == KIND_CHANGE || cmd.kind == KIND_DELETE) ? cmd.slot : 4'd0;
    end else if (ctl.add_write) begin
      hnd <= 4'(free_idx);
    end
  end

  // in-use flags, order stamp counter, fire count
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      order_cnt <= '0;
      nfire     <= '0;
    end else begin
      if (ctl.add_write) begin
        used[free_idx] <= 1'b1;
      end
      if (ctl.del_clear) begin
        used[req_idx] <= 1'b0;
      end
      if (ctl.fire) begin
        used[best_idx] <= 1'b0;
      end
      if (wr_en) begin
        order_cnt <= order_cnt + 64'd1;
      end
      if (ctl.capture) begin
        nfire <= '0;
      end else if (ctl.fire) begin
        nfire <= nfire + FIRE_W'(1);
      end
    end
  end

  // alarm record update from the scan result
  assign upd_time = best_found ? best_time : 64'd0;
  assign reprog   = best_found && (!alarm_en || (best_time != prog_time));

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_en  <= 1'b0;
      prog_time <= '0;
    end else if (ctl.emit_final && ctl.final_update) begin
      alarm_en  <= best_found;
      prog_time <= upd_time;
    end
  end

  // result register
  assign loading = ctl.fire || ctl.emit_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (loading) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      res.handle     <= 4'(best_idx);
      res.fired      <= 1'b1;
      res.fired_tag  <= best_tag;
      res.status     <= STATUS_OK;
      res.alarm_on   <= 1'b0;
      res.next_alarm <= '0;
      res.reprogram  <= 1'b0;
      res.last       <= 1'b0;
    end else if (ctl.emit_final) begin
      res.handle    <= hnd;
      res.fired     <= 1'b0;
      res.fired_tag <= '0;
      res.status    <= ctl.final_status;
      res.last      <= 1'b1;
      if (ctl.final_update) begin
        res.alarm_on   <= best_found;
        res.next_alarm <= upd_time;
        res.reprogram  <= reprog;
      end else begin
        res.alarm_on   <= alarm_en;
        res.next_alarm <= alarm_en ? prog_time : 64'd0;
        res.reprogram  <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.kind       = req.kind;
    sts.full       = full;
    sts.slot_ok    = slot_ok;
    sts.same_time  = (rd_time == req.alarm_at);
    sts.scan_end   = (scan_cnt == CW'(SLOTS));
    sts.fire_ready = best_found && (best_time <= req.now) &&
                     (nfire < FIRE_W'(MAX_FIRE));
    sts.out_free   = !res_valid || !res_stall;
  end

  // checks
  `OTQ_ASSERT_IMPL(a_no_overwrite, clk, rst, loading, sts.out_free, "result overwritten")
  `OTQ_ASSERT(a_fire_bound, clk, rst, nfire <= FIRE_W'(MAX_FIRE), "fire count above limit")
  `OTQ_ASSERT(a_alarm_cleared, clk, rst, alarm_en || (prog_time == '0), "disabled alarm kept")
  `OTQ_ASSERT_IMPL(a_fire_due, clk, rst, ctl.fire, best_found && (req.kind == KIND_EXPIRE), "stray fire")

endmodule

// File: hdl/ordered_timer_queue.sv
// ---------------------------------------------------------------------------
// ordered_timer_queue
// Table of pending timers ordered by alarm time, with add, change, delete
// and expire operations and a report of the earliest alarm.
// ---------------------------------------------------------------------------
// One operation is handled at a time. Add, delete, expire and a change to a
// new time scan all SLOTS entries through the single read port of the slot
// memories, one slot per cycle; a change first reads the old time. A full
// table, a bad handle or a change to the same time answer without a scan.
// An expire fires up to 16 timers and scans the table again after every
// timer that fires. Results leave through an output register; a stalled
// result holds the block until it is taken. A result with last set closes
// every operation; fired timers come before it in due order.
// ---------------------------------------------------------------------------
module ordered_timer_queue
  import otq_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  otq_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output otq_res_t res
);

  otq_ctl_t ctl;
  otq_sts_t sts;

  // sequencer
  otq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage, scan and result register
  otq_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
